// ===== hw/rtl/ecol_pkg.sv =====
`timescale 1ns / 1ps
package ecol_pkg;

    // fraction bits of the unit normal and of the mass weights
    localparam int QSH = 28;

    // pipeline depths
    localparam int FRONT_STAGES = 5;
    localparam int SQRT_STAGES  = 32;
    localparam int DIV_STAGES   = 30;
    localparam int MIX_STAGES   = 6;
    localparam int LAT_TOTAL    = FRONT_STAGES + SQRT_STAGES + 1 + DIV_STAGES + 1 + MIX_STAGES;

    localparam logic signed [67:0] HALF_Q = 68'sd1 <<< (QSH - 1);
    localparam logic signed [67:0] SAT_HI = 68'sd2147483647;
    localparam logic signed [67:0] SAT_LO = -68'sd2147483648;

    // input transaction
    typedef struct packed {
        logic signed [31:0] first_pos_x;
        logic signed [31:0] first_pos_y;
        logic signed [31:0] first_vel_x;
        logic signed [31:0] first_vel_y;
        logic        [30:0] first_mass;
        logic signed [31:0] second_pos_x;
        logic signed [31:0] second_pos_y;
        logic signed [31:0] second_vel_x;
        logic signed [31:0] second_vel_y;
        logic        [30:0] second_mass;
    } t_in;

    // result transaction
    typedef struct packed {
        logic signed [31:0] first_new_vel_x;
        logic signed [31:0] first_new_vel_y;
        logic signed [31:0] second_new_vel_x;
        logic signed [31:0] second_new_vel_y;
        logic               degenerate;
    } t_out;

    // per-item values that ride alongside the arithmetic units
    typedef struct packed {
        logic signed [31:0] v1x;
        logic signed [31:0] v1y;
        logic signed [31:0] v2x;
        logic signed [31:0] v2y;
        logic        [30:0] m1;
        logic        [30:0] m2;
        logic        [30:0] axn;
        logic        [30:0] ayn;
        logic               sx;
        logic               sy;
        logic               mneg;
        logic               degen;
    } t_side;

    // divide by 2^QSH, rounding half away from zero
    function automatic logic signed [67:0] rnd_q28(input logic signed [67:0] v);
        logic signed [67:0] adj;
        adj = v[67] ? (v + HALF_Q - 68'sd1) : (v + HALF_Q);
        return adj >>> QSH;
    endfunction

    // clamp to the 32 bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] res;
        if (v > SAT_HI) begin
            res = 32'sh7FFFFFFF;
        end else if (v < SAT_LO) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/ecol_front.sv =====
`timescale 1ns / 1ps
module ecol_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ecol_pkg::t_in   i_in,
    output logic            o_valid,
    output logic [62:0]     o_x,
    output ecol_pkg::t_side o_side
);
    import ecol_pkg::*;

    logic [FRONT_STAGES-1:0] r_vld;

    logic signed [32:0] n_dx;
    logic signed [32:0] n_dy;
    logic        [31:0] n_ax;
    logic        [31:0] n_ay;
    t_side              n_side;

    logic [31:0] r1_ax;
    logic [31:0] r1_ay;
    t_side       r1_side;

    logic [31:0] n_mx;
    logic [4:0]  n_msb;
    logic [31:0] r2_ax;
    logic [31:0] r2_ay;
    logic        r2_big;
    logic [4:0]  r2_sh;
    t_side       r2_side;

    t_side       n_s3;
    t_side       r3_side;
    logic [61:0] r4_sqx;
    logic [61:0] r4_sqy;
    t_side       r4_side;
    logic [62:0] r5_x;
    t_side       r5_side;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FRONT_STAGES-2:0], i_valid};
        end
    end

    // centre difference, magnitudes and special cases
    always_comb begin
        n_dx = 33'(i_in.first_pos_x) - 33'(i_in.second_pos_x);
        n_dy = 33'(i_in.first_pos_y) - 33'(i_in.second_pos_y);
        n_ax = n_dx[32] ? 32'(-n_dx) : n_dx[31:0];
        n_ay = n_dy[32] ? 32'(-n_dy) : n_dy[31:0];
        n_side       = '0;
        n_side.v1x   = i_in.first_vel_x;
        n_side.v1y   = i_in.first_vel_y;
        n_side.v2x   = i_in.second_vel_x;
        n_side.v2y   = i_in.second_vel_y;
        n_side.m1    = i_in.first_mass;
        n_side.m2    = i_in.second_mass;
        n_side.sx    = n_dx[32];
        n_side.sy    = n_dy[32];
        n_side.degen = ((n_dx == '0) && (n_dy == '0)) ||
                       ((i_in.first_mass == '0) && (i_in.second_mass == '0));
    end

    // normalize shift amount from the larger magnitude
    always_comb begin
        n_mx  = (r1_ax > r1_ay) ? r1_ax : r1_ay;
        n_msb = '0;
        for (int i = 0; i < 31; i++) begin
            if (n_mx[i]) begin
                n_msb = 5'(i);
            end
        end
    end

    // normalized magnitudes
    always_comb begin
        n_s3     = r2_side;
        n_s3.axn = r2_big ? r2_ax[31:1] : 31'(r2_ax << r2_sh);
        n_s3.ayn = r2_big ? r2_ay[31:1] : 31'(r2_ay << r2_sh);
    end

    // stages: latch, shift select, shift, square, sum
    always_ff @(posedge i_clk) begin
        r1_ax   <= n_ax;
        r1_ay   <= n_ay;
        r1_side <= n_side;

        r2_ax   <= r1_ax;
        r2_ay   <= r1_ay;
        r2_big  <= n_mx[31];
        r2_sh   <= 5'd30 - n_msb;
        r2_side <= r1_side;

        r3_side <= n_s3;

        r4_sqx  <= 62'(r3_side.axn) * 62'(r3_side.axn);
        r4_sqy  <= 62'(r3_side.ayn) * 62'(r3_side.ayn);
        r4_side <= r3_side;

        r5_x    <= 63'(r4_sqx) + 63'(r4_sqy);
        r5_side <= r4_side;
    end

    assign o_valid = r_vld[FRONT_STAGES-1];
    assign o_x     = r5_x;
    assign o_side  = r5_side;

endmodule

// ===== hw/rtl/ecol_sqrt.sv =====
`timescale 1ns / 1ps
module ecol_sqrt (
    input  logic        i_clk,
    input  logic [62:0] i_x,
    output logic [31:0] o_root
);
    import ecol_pkg::*;

    logic [63:0] r_rem     [SQRT_STAGES];
    logic [31:0] r_root    [SQRT_STAGES];
    logic [63:0] w_rem_in  [SQRT_STAGES];
    logic [31:0] w_root_in [SQRT_STAGES];

    // one root bit per stage, most significant first
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam int B = SQRT_STAGES - 1 - k;
        logic [63:0] w_trial;

        if (k == 0) begin : g_first
            assign w_rem_in[k]  = 64'(i_x);
            assign w_root_in[k] = '0;
        end else begin : g_next
            assign w_rem_in[k]  = r_rem[k-1];
            assign w_root_in[k] = r_root[k-1];
        end

        assign w_trial = (64'(w_root_in[k]) << (B + 1)) | (64'd1 << (2 * B));

        // trial subtract of the next root bit
        always_ff @(posedge i_clk) begin
            if (w_rem_in[k] >= w_trial) begin
                r_rem[k]  <= w_rem_in[k] - w_trial;
                r_root[k] <= w_root_in[k] | (32'd1 << B);
            end else begin
                r_rem[k]  <= w_rem_in[k];
                r_root[k] <= w_root_in[k];
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

// ===== hw/rtl/ecol_div.sv =====
`timescale 1ns / 1ps
module ecol_div (
    input  logic        i_clk,
    input  logic [61:0] i_num,
    input  logic [31:0] i_den,
    output logic [29:0] o_quot
);
    import ecol_pkg::*;

    logic [61:0] r_rem     [DIV_STAGES];
    logic [31:0] r_den     [DIV_STAGES];
    logic [29:0] r_quot    [DIV_STAGES];
    logic [61:0] w_rem_in  [DIV_STAGES];
    logic [31:0] w_den_in  [DIV_STAGES];
    logic [29:0] w_quot_in [DIV_STAGES];

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        localparam int B = DIV_STAGES - 1 - k;
        logic [61:0] w_trial;

        if (k == 0) begin : g_first
            assign w_rem_in[k]  = i_num;
            assign w_den_in[k]  = i_den;
            assign w_quot_in[k] = '0;
        end else begin : g_next
            assign w_rem_in[k]  = r_rem[k-1];
            assign w_den_in[k]  = r_den[k-1];
            assign w_quot_in[k] = r_quot[k-1];
        end

        assign w_trial = 62'(w_den_in[k]) << B;

        always_ff @(posedge i_clk) begin
            r_den[k] <= w_den_in[k];
            if (w_rem_in[k] >= w_trial) begin
                r_rem[k]  <= w_rem_in[k] - w_trial;
                r_quot[k] <= w_quot_in[k] | (30'd1 << B);
            end else begin
                r_rem[k]  <= w_rem_in[k];
                r_quot[k] <= w_quot_in[k];
            end
        end
    end

    assign o_quot = r_quot[DIV_STAGES-1];

endmodule

// ===== hw/rtl/ecol_mix.sv =====
`timescale 1ns / 1ps
module ecol_mix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [30:0] i_nx,
    input  logic signed [30:0] i_ny,
    input  logic signed [30:0] i_ka,
    input  logic signed [30:0] i_kb,
    input  logic signed [30:0] i_kc,
    input  ecol_pkg::t_side    i_side,
    output logic               o_valid,
    output ecol_pkg::t_out     o_out
);
    import ecol_pkg::*;

    logic [MIX_STAGES-1:0] r_vld;

    logic signed [67:0] r1_p [8];
    logic signed [30:0] r1_nx, r1_ny, r1_ka, r1_kb, r1_kc;
    t_side              r1_side;

    logic signed [35:0] r2_v1n, r2_v1t, r2_v2n, r2_v2t;
    logic signed [30:0] r2_nx, r2_ny, r2_ka, r2_kb, r2_kc;
    t_side              r2_side;

    logic signed [67:0] r3_q [4];
    logic signed [35:0] r3_v1t, r3_v2t;
    logic signed [30:0] r3_nx, r3_ny;
    t_side              r3_side;

    logic signed [35:0] r4_f1, r4_f2, r4_v1t, r4_v2t;
    logic signed [30:0] r4_nx, r4_ny;
    t_side              r4_side;

    logic signed [67:0] r5_e [8];
    t_side              r5_side;

    t_out               r_out;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[MIX_STAGES-2:0], i_valid};
        end
    end

    // projections onto normal and tangent
    always_ff @(posedge i_clk) begin
        r1_p[0] <= 68'(i_nx) * 68'(i_side.v1x);
        r1_p[1] <= 68'(i_ny) * 68'(i_side.v1y);
        r1_p[2] <= 68'(i_nx) * 68'(i_side.v1y);
        r1_p[3] <= 68'(i_ny) * 68'(i_side.v1x);
        r1_p[4] <= 68'(i_nx) * 68'(i_side.v2x);
        r1_p[5] <= 68'(i_ny) * 68'(i_side.v2y);
        r1_p[6] <= 68'(i_nx) * 68'(i_side.v2y);
        r1_p[7] <= 68'(i_ny) * 68'(i_side.v2x);
        r1_nx   <= i_nx;
        r1_ny   <= i_ny;
        r1_ka   <= i_ka;
        r1_kb   <= i_kb;
        r1_kc   <= i_kc;
        r1_side <= i_side;
    end

    // normal and tangential components
    always_ff @(posedge i_clk) begin
        r2_v1n  <= 36'(rnd_q28(r1_p[0] + r1_p[1]));
        r2_v1t  <= 36'(rnd_q28(r1_p[2] - r1_p[3]));
        r2_v2n  <= 36'(rnd_q28(r1_p[4] + r1_p[5]));
        r2_v2t  <= 36'(rnd_q28(r1_p[6] - r1_p[7]));
        r2_nx   <= r1_nx;
        r2_ny   <= r1_ny;
        r2_ka   <= r1_ka;
        r2_kb   <= r1_kb;
        r2_kc   <= r1_kc;
        r2_side <= r1_side;
    end

    // mass weighted exchange products
    always_ff @(posedge i_clk) begin
        r3_q[0] <= 68'(r2_ka) * 68'(r2_v1n);
        r3_q[1] <= 68'(r2_kb) * 68'(r2_v2n);
        r3_q[2] <= 68'(r2_kc) * 68'(r2_v1n);
        r3_q[3] <= 68'(r2_ka) * 68'(r2_v2n);
        r3_v1t  <= r2_v1t;
        r3_v2t  <= r2_v2t;
        r3_nx   <= r2_nx;
        r3_ny   <= r2_ny;
        r3_side <= r2_side;
    end

    // new normal components
    always_ff @(posedge i_clk) begin
        r4_f1   <= 36'(rnd_q28(r3_q[0] + r3_q[1]));
        r4_f2   <= 36'(rnd_q28(r3_q[2] - r3_q[3]));
        r4_v1t  <= r3_v1t;
        r4_v2t  <= r3_v2t;
        r4_nx   <= r3_nx;
        r4_ny   <= r3_ny;
        r4_side <= r3_side;
    end

    // rebuild products
    always_ff @(posedge i_clk) begin
        r5_e[0] <= 68'(r4_f1) * 68'(r4_nx);
        r5_e[1] <= 68'(r4_v1t) * 68'(r4_ny);
        r5_e[2] <= 68'(r4_f1) * 68'(r4_ny);
        r5_e[3] <= 68'(r4_v1t) * 68'(r4_nx);
        r5_e[4] <= 68'(r4_f2) * 68'(r4_nx);
        r5_e[5] <= 68'(r4_v2t) * 68'(r4_ny);
        r5_e[6] <= 68'(r4_f2) * 68'(r4_ny);
        r5_e[7] <= 68'(r4_v2t) * 68'(r4_nx);
        r5_side <= r4_side;
    end

    // final velocities, bypass on degenerate input
    always_ff @(posedge i_clk) begin
        r_out.degenerate <= r5_side.degen;
        if (r5_side.degen) begin
            r_out.first_new_vel_x  <= r5_side.v1x;
            r_out.first_new_vel_y  <= r5_side.v1y;
            r_out.second_new_vel_x <= r5_side.v2x;
            r_out.second_new_vel_y <= r5_side.v2y;
        end else begin
            r_out.first_new_vel_x  <= sat32(rnd_q28(r5_e[0] - r5_e[1]));
            r_out.first_new_vel_y  <= sat32(rnd_q28(r5_e[2] + r5_e[3]));
            r_out.second_new_vel_x <= sat32(rnd_q28(r5_e[4] - r5_e[5]));
            r_out.second_new_vel_y <= sat32(rnd_q28(r5_e[6] + r5_e[7]));
        end
    end

    assign o_valid = r_vld[MIX_STAGES-1];
    assign o_out   = r_out;

    a_valid_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_valid, MIX_STAGES))
        else $error("mix result without a matching entry");

    a_degen_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.degenerate == $past(i_side.degen, MIX_STAGES)))
        else $error("degenerate flag out of step with its transaction");

    a_degen_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.degenerate) |->
        ((o_out.first_new_vel_x == $past(i_side.v1x, MIX_STAGES)) &&
         (o_out.second_new_vel_y == $past(i_side.v2y, MIX_STAGES))))
        else $error("degenerate transaction did not pass velocities through");

endmodule

// ===== hw/rtl/elastic_collision_2d_unit.sv =====
`timescale 1ns / 1ps
// Elastic collision of two circles in Q16.16. Pulse start with a transaction on i_in in
// any cycle; busy is always low, so a new transaction is taken every clock. Each result
// appears on o_out with o_done high for a single cycle, in input order, and must be
// captured then since the block cannot be held off. The pipeline has 5 front stages
// (difference, normalize, squares), 32 square root stages (one root bit each), one
// numerator stage, 30 divider stages (one quotient bit each, for the unit normal and
// the mass weights), one sign stage and 6 stages of projection, exchange and rebuild
// multiplies.
module elastic_collision_2d_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ecol_pkg::t_in  i_in,
    output logic           o_done,
    output ecol_pkg::t_out o_out
);
    import ecol_pkg::*;

    logic        f_vld;
    logic [62:0] f_x;
    t_side       f_side;
    logic [31:0] s_root;

    t_side                  r_sa [SQRT_STAGES];
    logic [SQRT_STAGES-1:0] r_va;

    logic        [31:0] n_msum;
    logic        [30:0] n_dm;
    t_side              n_n_side;
    logic               r_n_vld;
    t_side              r_n_side;
    logic        [61:0] r_num_x, r_num_y, r_num_a, r_num_b, r_num_c;
    logic        [31:0] r_den_r, r_den_m;

    logic [29:0] q_x, q_y, q_a, q_b, q_c;

    t_side                 r_sb [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_vb;

    logic               r_g_vld;
    logic signed [30:0] r_g_nx, r_g_ny, r_g_ka, r_g_kb, r_g_kc;
    t_side              r_g_side;

    assign busy = 1'b0;

    ecol_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_in    (i_in),
        .o_valid (f_vld),
        .o_x     (f_x),
        .o_side  (f_side)
    );

    ecol_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_x    (f_x),
        .o_root (s_root)
    );

    // side values alongside the square root
    always_ff @(posedge i_clk) begin
        r_sa[0] <= f_side;
        for (int k = 1; k < SQRT_STAGES; k++) begin
            r_sa[k] <= r_sa[k-1];
        end
    end

    // numerators and divisors
    always_comb begin
        n_msum = 32'(r_sa[SQRT_STAGES-1].m1) + 32'(r_sa[SQRT_STAGES-1].m2);
        n_dm   = (r_sa[SQRT_STAGES-1].m1 < r_sa[SQRT_STAGES-1].m2) ?
                 (r_sa[SQRT_STAGES-1].m2 - r_sa[SQRT_STAGES-1].m1) :
                 (r_sa[SQRT_STAGES-1].m1 - r_sa[SQRT_STAGES-1].m2);
        n_n_side      = r_sa[SQRT_STAGES-1];
        n_n_side.mneg = r_sa[SQRT_STAGES-1].m1 < r_sa[SQRT_STAGES-1].m2;
    end

    always_ff @(posedge i_clk) begin
        r_n_side <= n_n_side;
        r_num_x <= (62'(r_sa[SQRT_STAGES-1].axn) << QSH) + 62'(s_root[31:1]);
        r_num_y <= (62'(r_sa[SQRT_STAGES-1].ayn) << QSH) + 62'(s_root[31:1]);
        r_num_a <= (62'(n_dm) << QSH) + 62'(n_msum[31:1]);
        r_num_b <= (62'(r_sa[SQRT_STAGES-1].m2) << (QSH + 1)) + 62'(n_msum[31:1]);
        r_num_c <= (62'(r_sa[SQRT_STAGES-1].m1) << (QSH + 1)) + 62'(n_msum[31:1]);
        r_den_r <= s_root;
        r_den_m <= n_msum;
    end

    ecol_div u_div_x (.i_clk(i_clk), .i_num(r_num_x), .i_den(r_den_r), .o_quot(q_x));
    ecol_div u_div_y (.i_clk(i_clk), .i_num(r_num_y), .i_den(r_den_r), .o_quot(q_y));
    ecol_div u_div_a (.i_clk(i_clk), .i_num(r_num_a), .i_den(r_den_m), .o_quot(q_a));
    ecol_div u_div_b (.i_clk(i_clk), .i_num(r_num_b), .i_den(r_den_m), .o_quot(q_b));
    ecol_div u_div_c (.i_clk(i_clk), .i_num(r_num_c), .i_den(r_den_m), .o_quot(q_c));

    // side values alongside the dividers
    always_ff @(posedge i_clk) begin
        r_sb[0] <= r_n_side;
        for (int k = 1; k < DIV_STAGES; k++) begin
            r_sb[k] <= r_sb[k-1];
        end
    end

    // apply signs to the normal and the first weight
    always_ff @(posedge i_clk) begin
        r_g_nx   <= r_sb[DIV_STAGES-1].sx ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
        r_g_ny   <= r_sb[DIV_STAGES-1].sy ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
        r_g_ka   <= r_sb[DIV_STAGES-1].mneg ? -$signed({1'b0, q_a}) : $signed({1'b0, q_a});
        r_g_kb   <= $signed({1'b0, q_b});
        r_g_kc   <= $signed({1'b0, q_c});
        r_g_side <= r_sb[DIV_STAGES-1];
    end

    // valid bits of the middle section
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va    <= '0;
            r_n_vld <= 1'b0;
            r_vb    <= '0;
            r_g_vld <= 1'b0;
        end else begin
            r_va    <= {r_va[SQRT_STAGES-2:0], f_vld};
            r_n_vld <= r_va[SQRT_STAGES-1];
            r_vb    <= {r_vb[DIV_STAGES-2:0], r_n_vld};
            r_g_vld <= r_vb[DIV_STAGES-1];
        end
    end

    ecol_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_g_vld),
        .i_nx    (r_g_nx),
        .i_ny    (r_g_ny),
        .i_ka    (r_g_ka),
        .i_kb    (r_g_kb),
        .i_kc    (r_g_kc),
        .i_side  (r_g_side),
        .o_valid (o_done),
        .o_out   (o_out)
    );

    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT_TOTAL))
        else $error("result strobe without a transaction at the expected latency");

    a_mid_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_g_vld |-> $past(f_vld, SQRT_STAGES + DIV_STAGES + 2))
        else $error("divider output valid out of step with the front end");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> !busy)
        else $error("block stalled the input");

endmodule

// ===== test/elastic_collision_2d_checker.sv =====
`timescale 1ns / 1ps
module elastic_collision_2d_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  ecol_pkg::t_in  i_in,
    input  logic           i_done,
    input  ecol_pkg::t_out i_out,
    output int             o_errors,
    output int             o_pending
);
    import ecol_pkg::*;

    t_out pending_velocities[$];

    // divide by 2^28, rounding half away from zero
    function automatic longint q28_round(input longint v);
        longint m;
        if (v < 0) begin
            m = -v;
            return -((m + (64'sd1 <<< 27)) >>> 28);
        end
        return (v + (64'sd1 <<< 27)) >>> 28;
    endfunction

    function automatic longint div_round(input longint num, input longint den);
        if (num < 0) return -((-num + den / 2) / den);
        return (num + den / 2) / den;
    endfunction

    function automatic longint int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // velocities after the collision of one body pair
    function automatic t_out collide(input t_in t);
        t_out res;
        longint v1x, v1y, v2x, v2y, m1, m2, msum, dx, dy;
        longint ax, ay, mx, r, nx, ny, ka, kb, kc, v1n, v1t, v2n, v2t, f1, f2;
        v1x = t.first_vel_x;
        v1y = t.first_vel_y;
        v2x = t.second_vel_x;
        v2y = t.second_vel_y;
        m1 = {33'd0, t.first_mass};
        m2 = {33'd0, t.second_mass};
        msum = m1 + m2;
        dx = longint'(t.first_pos_x) - longint'(t.second_pos_x);
        dy = longint'(t.first_pos_y) - longint'(t.second_pos_y);
        if ((dx == 0 && dy == 0) || msum == 0) begin
            res.first_new_vel_x = t.first_vel_x;
            res.first_new_vel_y = t.first_vel_y;
            res.second_new_vel_x = t.second_vel_x;
            res.second_new_vel_y = t.second_vel_y;
            res.degenerate = 1'b1;
            return res;
        end
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        mx = ax > ay ? ax : ay;
        // scale the difference so that its larger magnitude lies in [2^30, 2^31)
        if (mx >= (64'sd1 <<< 31)) begin
            ax = ax >>> 1;
            ay = ay >>> 1;
        end else begin
            while (mx < (64'sd1 <<< 30)) begin
                ax = ax <<< 1;
                ay = ay <<< 1;
                mx = mx <<< 1;
            end
        end
        r = int_sqrt(ax * ax + ay * ay);
        nx = ((ax <<< 28) + r / 2) / r;
        ny = ((ay <<< 28) + r / 2) / r;
        if (dx < 0) nx = -nx;
        if (dy < 0) ny = -ny;
        ka = div_round((m1 - m2) <<< 28, msum);
        kb = div_round(m2 <<< 29, msum);
        kc = div_round(m1 <<< 29, msum);
        v1n = q28_round(nx * v1x + ny * v1y);
        v1t = q28_round(nx * v1y - ny * v1x);
        v2n = q28_round(nx * v2x + ny * v2y);
        v2t = q28_round(nx * v2y - ny * v2x);
        f1 = q28_round(ka * v1n + kb * v2n);
        f2 = q28_round(kc * v1n - ka * v2n);
        res.first_new_vel_x = clamp32(q28_round(f1 * nx - v1t * ny));
        res.first_new_vel_y = clamp32(q28_round(f1 * ny + v1t * nx));
        res.second_new_vel_x = clamp32(q28_round(f2 * nx - v2t * ny));
        res.second_new_vel_y = clamp32(q28_round(f2 * ny + v2t * nx));
        res.degenerate = 1'b0;
        return res;
    endfunction

    assign o_pending = pending_velocities.size();

    // predict on accepted inputs, compare on each result strobe
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_done) begin
                if (pending_velocities.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out);
                    o_errors <= o_errors + 1;
                end else begin
                    want = pending_velocities.pop_front();
                    if (want.first_new_vel_x !== i_out.first_new_vel_x ||
                        want.first_new_vel_y !== i_out.first_new_vel_y ||
                        want.second_new_vel_x !== i_out.second_new_vel_x ||
                        want.second_new_vel_y !== i_out.second_new_vel_y ||
                        want.degenerate !== i_out.degenerate) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, i_out);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_start && !i_busy) pending_velocities.push_back(collide(i_in));
        end
    end
endmodule

// ===== test/elastic_collision_2d_unit_test.sv =====
`timescale 1ns / 1ps
module elastic_collision_2d_unit_test;
    import ecol_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  i_in = '0;
    logic o_done;
    t_out o_out;
    int   error_count;
    int   waiting;
    int   sent;
    int   degenerate_sent;

    always #10 i_clk = ~i_clk;

    elastic_collision_2d_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in(i_in), .o_done(o_done), .o_out(o_out)
    );

    elastic_collision_2d_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_in(i_in),
        .i_done(o_done), .i_out(o_out), .o_errors(error_count), .o_pending(waiting)
    );

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return $urandom_range(0, 2000) - 1000;
            3: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] pick_mass();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 31'h7FFFFFFF;
            2: return 31'($urandom_range(1, 32'h0010_0000));
            default: return 31'($urandom);
        endcase
    endfunction

    // present one transaction, then optionally idle
    task automatic send(input t_in t);
        int gap;
        i_in <= t;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
        if (t.first_mass == 0 && t.second_mass == 0) degenerate_sent++;
        gap = ($urandom_range(0, 3) == 0) ? 0 : 0;
        if ($urandom_range(0, 9) < 3) gap = $urandom_range(1, 3);
        if ($urandom_range(0, 49) == 0) gap = $urandom_range(10, 90);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_fields(input logic [31:0] p1x, p1y, v1x, v1y, input logic [30:0] m1,
                               input logic [31:0] p2x, p2y, v2x, v2y, input logic [30:0] m2);
        t_in t;
        t = '{p1x, p1y, v1x, v1y, m1, p2x, p2y, v2x, v2y, m2};
        send(t);
    endtask

    initial begin
        t_in t;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: head-on, equal masses, extremes, degenerate cases
        send_fields(32'h10000, 0, 32'hFFFF0000, 0, 31'h10000,
                    0, 0, 32'h10000, 0, 31'h10000);
        send_fields(0, 32'h10000, 32'h30000, 32'h20000, 31'h20000,
                    0, 0, 0, 32'hFFFF0000, 31'h10000);
        send_fields(5, 5, 32'h1234, 32'h5678, 31'h10000, 5, 5, 32'h9ABC, 32'hDEF0, 31'h10000);
        send_fields(1, 2, 32'h1234, 32'h5678, 31'd0, 3, 4, 32'h9ABC, 32'hDEF0, 31'd0);
        send_fields(1, 0, 32'h10000, 0, 31'd0, 0, 0, 32'h0, 0, 31'h10000);
        send_fields(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF,
                    32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF);
        send_fields(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 31'd1,
                    32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF);
        send_fields(32'h80000000, 0, 32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF,
                    32'h7FFFFFFF, 0, 32'h80000000, 32'h7FFFFFFF, 31'd0);
        send_fields(0, 1, 32'hFFFFFFFF, 1, 31'd1, 0, 0, 1, 32'hFFFFFFFF, 31'd1);
        send_fields(3, 4, 32'h7FFFFFFF, 0, 31'h7FFFFFFF, 0, 0, 32'h80000000, 0, 31'd1);
        send_fields(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h40000, 32'hFFFC0000, 31'h8000,
                    0, 0, 32'hFFFE0000, 32'h20000, 31'h18000);
        send_fields(32'h40000000, 32'hC0000000, 32'h100, 32'h200, 31'h40000000,
                    32'hC0000000, 32'h40000000, 32'h300, 32'h400, 31'h3FFFFFFF);
        // random collision pairs, with a share of coinciding centres
        repeat (650) begin
            t.first_pos_x = pick_word();
            t.first_pos_y = pick_word();
            t.first_vel_x = pick_word();
            t.first_vel_y = pick_word();
            t.first_mass = pick_mass();
            t.second_pos_x = ($urandom_range(0, 19) == 0) ? t.first_pos_x : pick_word();
            t.second_pos_y = ($urandom_range(0, 19) == 0) ? t.first_pos_y : pick_word();
            t.second_vel_x = pick_word();
            t.second_vel_y = pick_word();
            t.second_mass = pick_mass();
            send(t);
        end
        start <= 1'b0;
        while (waiting != 0) @(posedge i_clk);
        repeat (LAT_TOTAL + 10) @(posedge i_clk);
        $display("covered %0d collision pairs with directed extremes and random gaps", sent);
        $display("including %0d with both masses zero", degenerate_sent);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
